// ===== sv/tilt_pkg.sv =====
// Shared types and constants for the accelerometer tilt-angle pipeline.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package tilt_pkg;

    localparam int RAW_W        = 24;   // raw sensor word
    localparam int SMP_LSB      = 4;    // sample sits in bits 23..4
    localparam int MAG_W        = 20;   // magnitude of a 20-bit sample
    localparam int SQ_W         = 40;   // square and sum of two squares
    localparam int BLEN_W       = 6;    // bit length of a sum, 0..40
    localparam int K_W          = 5;    // common scale exponent, 11..31
    localparam int RV_W         = 64;   // radicand after scaling
    localparam int ROOT_STEPS   = 32;   // two radicand bits per stage, 62 down to 0
    localparam int ROOT_W       = 31;
    localparam int AMAG_W       = 51;   // scaled plain magnitude
    localparam int CW           = 56;   // CORDIC x/y datapath
    localparam int ACC_W        = 32;   // angle accumulator, degrees Q24
    localparam int ACC_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int ANGLE_W      = 16;
    localparam int NUM_AXES     = 3;

    // atan(2^-i) in degrees with 24 fraction bits.
    localparam logic signed [ACC_W-1:0] STEP_ANGLE [0:CORDIC_STEPS-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489089, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234683,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7
    };

    // Facts about one angle that are known before the root and CORDIC run.
    typedef struct packed {
        logic neg;      // exactly one of numerator and denominator negative
        logic n_zero;   // numerator is zero
        logic d_zero;   // denominator is zero
    } t_side;

endpackage

`default_nettype wire

// ===== sv/tilt_in_if.sv =====
// Input channel of the tilt-angle block: three raw accelerometer words.
// Depends on tilt_pkg for the word width.
`default_nettype none

interface tilt_in_if;
    logic                           valid;
    logic                           ready;
    logic [tilt_pkg::RAW_W-1:0]     raw_x;
    logic [tilt_pkg::RAW_W-1:0]     raw_y;
    logic [tilt_pkg::RAW_W-1:0]     raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

`default_nettype wire

// ===== sv/tilt_out_if.sv =====
// Output channel of the tilt-angle block: three angles and the undefined mask.
// Depends on tilt_pkg for the angle width.
`default_nettype none

interface tilt_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tilt_pkg::ANGLE_W-1:0]    angle_x;
    logic signed [tilt_pkg::ANGLE_W-1:0]    angle_y;
    logic signed [tilt_pkg::ANGLE_W-1:0]    angle_z;
    logic [tilt_pkg::NUM_AXES-1:0]          undefined_mask;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    output undefined_mask, input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    input undefined_mask, output ready);
endinterface

`default_nettype wire

// ===== sv/tilt_root.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a companion magnitude and the side flags alongside. Uses tilt_pkg.
`default_nettype none

module tilt_root (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_vld,
    input  wire logic [tilt_pkg::RV_W-1:0]      i_v,
    input  wire logic [tilt_pkg::AMAG_W-1:0]    i_comp,
    input  wire tilt_pkg::t_side                i_side,
    output logic                                o_vld,
    output logic [tilt_pkg::ROOT_W-1:0]         o_root,
    output logic [tilt_pkg::AMAG_W-1:0]         o_comp,
    output tilt_pkg::t_side                     o_side
);
    localparam int N = tilt_pkg::ROOT_STEPS;

    logic [N:0]                         w_vld;
    logic [tilt_pkg::RV_W-1:0]          w_v    [0:N];
    logic [tilt_pkg::RV_W-1:0]          w_res  [0:N];
    logic [tilt_pkg::AMAG_W-1:0]        w_comp [0:N];
    tilt_pkg::t_side                    w_side [0:N];

    assign w_vld[0]  = i_vld;
    assign w_v[0]    = i_v;
    assign w_res[0]  = '0;
    assign w_comp[0] = i_comp;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [tilt_pkg::RV_W-1:0] BIT =
            {{(tilt_pkg::RV_W-1){1'b0}}, 1'b1} << (tilt_pkg::RV_W - 2 - 2 * i);

        logic                           r_vld;
        logic [tilt_pkg::RV_W-1:0]      r_v, r_res, n_v, n_res, trial;
        logic [tilt_pkg::AMAG_W-1:0]    r_comp;
        tilt_pkg::t_side                r_side;

        always_comb begin
            trial = w_res[i] + BIT;
            if (w_v[i] >= trial) begin
                n_v   = w_v[i] - trial;
                n_res = (w_res[i] >> 1) + BIT;
            end else begin
                n_v   = w_v[i];
                n_res = w_res[i] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[i];
            end
            if (i_en) begin
                r_v    <= n_v;
                r_res  <= n_res;
                r_comp <= w_comp[i];
                r_side <= w_side[i];
            end
        end

        assign w_vld[i+1]  = r_vld;
        assign w_v[i+1]    = r_v;
        assign w_res[i+1]  = r_res;
        assign w_comp[i+1] = r_comp;
        assign w_side[i+1] = r_side;
    end

    assign o_vld  = w_vld[N];
    assign o_root = w_res[N][tilt_pkg::ROOT_W-1:0];
    assign o_comp = w_comp[N];
    assign o_side = w_side[N];

endmodule

`default_nettype wire

// ===== sv/tilt_cordic.sv =====
// Pipelined vectoring CORDIC giving atan(n/d) in degrees, one step per stage,
// followed by the rounding, special-case and saturation stage. Uses tilt_pkg.
`default_nettype none

module tilt_cordic #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_vld,
    input  wire logic [tilt_pkg::AMAG_W-1:0]        i_n,
    input  wire logic [tilt_pkg::AMAG_W-1:0]        i_d,
    input  wire tilt_pkg::t_side                    i_side,
    output logic                                    o_vld,
    output logic signed [tilt_pkg::ANGLE_W-1:0]     o_angle,
    output logic                                    o_undef
);
    localparam int N  = tilt_pkg::CORDIC_STEPS;
    localparam int SH = tilt_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [tilt_pkg::ACC_W-1:0] ACC_MAX  = 90 <<< tilt_pkg::ACC_FRAC;
    localparam logic signed [tilt_pkg::ACC_W-1:0] HALF     = 1 <<< (SH - 1);
    localparam logic signed [tilt_pkg::ACC_W-1:0] RIGHT    = 90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [tilt_pkg::ACC_W-1:0] SAT_HI   = (1 <<< (tilt_pkg::ANGLE_W - 1)) - 1;
    localparam logic signed [tilt_pkg::ACC_W-1:0] SAT_LO   = -(1 <<< (tilt_pkg::ANGLE_W - 1));

    logic [N:0]                             w_vld;
    logic signed [tilt_pkg::CW-1:0]         w_x   [0:N];
    logic signed [tilt_pkg::CW-1:0]         w_y   [0:N];
    logic signed [tilt_pkg::ACC_W-1:0]      w_acc [0:N];
    tilt_pkg::t_side                        w_side [0:N];

    assign w_vld[0]  = i_vld;
    assign w_x[0]    = {{(tilt_pkg::CW-tilt_pkg::AMAG_W){1'b0}}, i_d};
    assign w_y[0]    = {{(tilt_pkg::CW-tilt_pkg::AMAG_W){1'b0}}, i_n};
    assign w_acc[0]  = '0;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                               r_vld;
        logic signed [tilt_pkg::CW-1:0]     r_x, r_y, n_x, n_y, xs, ys;
        logic signed [tilt_pkg::ACC_W-1:0]  r_acc, n_acc;
        tilt_pkg::t_side                    r_side;

        always_comb begin
            xs = w_x[i] >>> i;
            ys = w_y[i] >>> i;
            if (w_y[i] > 0) begin
                n_x   = w_x[i] + ys;
                n_y   = w_y[i] - xs;
                n_acc = w_acc[i] + tilt_pkg::STEP_ANGLE[i];
            end else begin
                n_x   = w_x[i] - ys;
                n_y   = w_y[i] + xs;
                n_acc = w_acc[i] - tilt_pkg::STEP_ANGLE[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[i];
            end
            if (i_en) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_acc  <= n_acc;
                r_side <= w_side[i];
            end
        end

        assign w_vld[i+1]  = r_vld;
        assign w_x[i+1]    = r_x;
        assign w_y[i+1]    = r_y;
        assign w_acc[i+1]  = r_acc;
        assign w_side[i+1] = r_side;
    end

    logic signed [tilt_pkg::ACC_W-1:0]      acc_c, mag, sgn;
    logic signed [tilt_pkg::ANGLE_W-1:0]    n_angle;
    logic                                   r_vld;
    logic signed [tilt_pkg::ANGLE_W-1:0]    r_angle;
    logic                                   r_undef;

    always_comb begin
        if (w_acc[N] < 0) begin
            acc_c = '0;
        end else if (w_acc[N] > ACC_MAX) begin
            acc_c = ACC_MAX;
        end else begin
            acc_c = w_acc[N];
        end
        mag = (acc_c + HALF) >>> SH;
        // A zero numerator gives 0, also over a zero denominator.
        if (w_side[N].n_zero) begin
            mag = '0;
        end else if (w_side[N].d_zero) begin
            mag = RIGHT;
        end
        sgn = w_side[N].neg ? -mag : mag;
        if (sgn > SAT_HI) begin
            n_angle = SAT_HI[tilt_pkg::ANGLE_W-1:0];
        end else if (sgn < SAT_LO) begin
            n_angle = SAT_LO[tilt_pkg::ANGLE_W-1:0];
        end else begin
            n_angle = sgn[tilt_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= w_vld[N];
        end
        if (i_en) begin
            r_angle <= n_angle;
            r_undef <= w_side[N].n_zero & w_side[N].d_zero;
        end
    end

    assign o_vld   = r_vld;
    assign o_angle = r_angle;
    assign o_undef = r_undef;

endmodule

`default_nettype wire

// ===== sv/tilt_angles_from_accel.sv =====
// Channel    Dir  Payload                                      Handshake
// i_in       in   raw_x, raw_y, raw_z (24 b each)               valid/ready
// o_out      out  angle_x/y/z (s16, deg Q8), undefined_mask (3) valid/ready
//
// One item per cycle when the output is not stalled; there are 5 front stages, 32 root
// stages, 28 CORDIC stages and 1 output stage.
// All stages move together on one enable; the pipeline holds when the output
// register is full and not taken, and no item is lost or repeated.
// Reset is synchronous and active low and clears only the valid bits.
// Depends on tilt_pkg, tilt_in_if, tilt_out_if, tilt_root and tilt_cordic.
`default_nettype none

module tilt_angles_from_accel #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tilt_in_if.sink     i_in,
    tilt_out_if.source  o_out
);
    localparam int A = tilt_pkg::NUM_AXES;

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    logic [tilt_pkg::RAW_W-1:0] raw [0:A-1];
    assign raw[0] = i_in.raw_x;
    assign raw[1] = i_in.raw_y;
    assign raw[2] = i_in.raw_z;

    // Stage 1: sample magnitudes and signs.
    logic                           r1_vld;
    logic [A-1:0]                   r1_neg;
    logic [tilt_pkg::MAG_W-1:0]     r1_mag [0:A-1];
    // Stage 2: squares.
    logic                           r2_vld;
    logic [A-1:0]                   r2_neg;
    logic [tilt_pkg::MAG_W-1:0]     r2_mag [0:A-1];
    logic [tilt_pkg::SQ_W-1:0]      r2_sq  [0:A-1];
    // Stage 3: sum of the two other squares per axis.
    logic                           r3_vld;
    logic [A-1:0]                   r3_neg;
    logic [tilt_pkg::MAG_W-1:0]     r3_mag [0:A-1];
    logic [tilt_pkg::SQ_W-1:0]      r3_sum [0:A-1];
    // Stage 4: common scale exponent.
    logic                           r4_vld;
    logic [A-1:0]                   r4_neg;
    logic [tilt_pkg::MAG_W-1:0]     r4_mag [0:A-1];
    logic [tilt_pkg::SQ_W-1:0]      r4_sum [0:A-1];
    logic [tilt_pkg::K_W-1:0]       r4_k   [0:A-1];
    // Stage 5: scaled radicand and plain magnitude.
    logic                           r5_vld;
    logic [tilt_pkg::RV_W-1:0]      r5_v    [0:A-1];
    logic [tilt_pkg::AMAG_W-1:0]    r5_a    [0:A-1];
    tilt_pkg::t_side                r5_side [0:A-1];

    logic [tilt_pkg::MAG_W-1:0]     n_mag  [0:A-1];
    logic [tilt_pkg::SQ_W-1:0]      mag_w  [0:A-1];
    logic [tilt_pkg::BLEN_W-1:0]    blen   [0:A-1];
    logic [tilt_pkg::BLEN_W-1:0]    kdbl   [0:A-1];
    logic [tilt_pkg::RV_W-1:0]      sum_w  [0:A-1];
    logic [tilt_pkg::AMAG_W-1:0]    amag_w [0:A-1];

    always_comb begin
        for (int a = 0; a < A; a++) begin
            if (raw[a][tilt_pkg::RAW_W-1]) begin
                n_mag[a] = ~raw[a][tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB]
                         + {{(tilt_pkg::MAG_W-1){1'b0}}, 1'b1};
            end else begin
                n_mag[a] = raw[a][tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB];
            end
            mag_w[a] = {{(tilt_pkg::SQ_W-tilt_pkg::MAG_W){1'b0}}, r1_mag[a]};
            blen[a] = '0;
            for (int j = 0; j < tilt_pkg::SQ_W; j++) begin
                if (r3_sum[a][j]) begin
                    blen[a] = tilt_pkg::BLEN_W'(j + 1);
                end
            end
            kdbl[a]   = (tilt_pkg::BLEN_W'(tilt_pkg::RV_W - 2) - blen[a]) >> 1;
            sum_w[a]  = {{(tilt_pkg::RV_W-tilt_pkg::SQ_W){1'b0}}, r4_sum[a]};
            amag_w[a] = {{(tilt_pkg::AMAG_W-tilt_pkg::MAG_W){1'b0}}, r4_mag[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
        if (en) begin
            for (int a = 0; a < A; a++) begin
                r1_neg[a] <= raw[a][tilt_pkg::RAW_W-1];
                r1_mag[a] <= n_mag[a];
                r2_mag[a] <= r1_mag[a];
                r2_sq[a]  <= mag_w[a] * mag_w[a];
                r3_mag[a] <= r2_mag[a];
                r4_mag[a] <= r3_mag[a];
                r4_sum[a] <= r3_sum[a];
                r4_k[a]   <= kdbl[a][tilt_pkg::K_W-1:0];
                r5_v[a]   <= sum_w[a] << {r4_k[a], 1'b0};
                r5_a[a]   <= amag_w[a] << r4_k[a];
            end
            r2_neg    <= r1_neg;
            r3_neg    <= r2_neg;
            r4_neg    <= r3_neg;
            r3_sum[0] <= r2_sq[1] + r2_sq[2];
            r3_sum[1] <= r2_sq[0] + r2_sq[2];
            r3_sum[2] <= r2_sq[0] + r2_sq[1];
            // X and Y: plain axis over root; Z: root over plain axis.
            r5_side[0] <= '{neg: r4_neg[0], n_zero: r4_mag[0] == '0, d_zero: r4_sum[0] == '0};
            r5_side[1] <= '{neg: r4_neg[1], n_zero: r4_mag[1] == '0, d_zero: r4_sum[1] == '0};
            r5_side[2] <= '{neg: r4_neg[2], n_zero: r4_sum[2] == '0, d_zero: r4_mag[2] == '0};
        end
    end

    logic [A-1:0]                   root_vld;
    logic [tilt_pkg::ROOT_W-1:0]    root     [0:A-1];
    logic [tilt_pkg::AMAG_W-1:0]    root_ext [0:A-1];
    logic [tilt_pkg::AMAG_W-1:0]    comp     [0:A-1];
    tilt_pkg::t_side                side     [0:A-1];
    logic [A-1:0]                   ang_vld;
    logic [A-1:0]                   undef;
    logic signed [tilt_pkg::ANGLE_W-1:0] angle [0:A-1];

    for (genvar a = 0; a < A; a++) begin : g_axis
        tilt_root u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (r5_vld),
            .i_v     (r5_v[a]),
            .i_comp  (r5_a[a]),
            .i_side  (r5_side[a]),
            .o_vld   (root_vld[a]),
            .o_root  (root[a]),
            .o_comp  (comp[a]),
            .o_side  (side[a])
        );

        assign root_ext[a] = {{(tilt_pkg::AMAG_W-tilt_pkg::ROOT_W){1'b0}}, root[a]};

        tilt_cordic #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (root_vld[a]),
            .i_n     ((a == A - 1) ? root_ext[a] : comp[a]),
            .i_d     ((a == A - 1) ? comp[a] : root_ext[a]),
            .i_side  (side[a]),
            .o_vld   (ang_vld[a]),
            .o_angle (angle[a]),
            .o_undef (undef[a])
        );
    end

    assign o_out.valid          = &ang_vld;
    assign o_out.angle_x        = angle[0];
    assign o_out.angle_y        = angle[1];
    assign o_out.angle_z        = angle[2];
    assign o_out.undefined_mask = undef;

    localparam int LIM_RAW = 90 << ANGLE_FRAC_BITS;
    localparam int LIM     = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

    a_undef_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.undefined_mask != '0 |->
            (!o_out.undefined_mask[0] || o_out.angle_x == 0) &&
            (!o_out.undefined_mask[1] || o_out.angle_y == 0) &&
            (!o_out.undefined_mask[2] || o_out.angle_z == 0))
        else $error("undefined angle not forced to zero");

    a_ready_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            $signed(o_out.angle_x) <= LIM && $signed(o_out.angle_x) >= -LIM &&
            $signed(o_out.angle_y) <= LIM && $signed(o_out.angle_y) >= -LIM &&
            $signed(o_out.angle_z) <= LIM && $signed(o_out.angle_z) >= -LIM)
        else $error("angle beyond ninety degrees");

    a_lanes_even : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ang_vld == '0 || ang_vld == '1)
        else $error("axis lanes out of step");

endmodule

`default_nettype wire

// ===== sim/tb_tilt_angles_from_accel.sv =====
// Testbench for tilt_angles_from_accel: drives raw accelerometer words and checks
// the three tilt angles and the undefined mask against a bit-exact predictor.
// Depends on tilt_pkg, tilt_in_if, tilt_out_if and the block's RTL.
`timescale 1ns / 100ps

module tb_tilt_angles_from_accel;

    localparam int FRAC        = 8;
    localparam int LATENCY     = 66;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [tilt_pkg::ANGLE_W-1:0] ax;
        logic signed [tilt_pkg::ANGLE_W-1:0] ay;
        logic signed [tilt_pkg::ANGLE_W-1:0] az;
        logic [tilt_pkg::NUM_AXES-1:0]       mask;
    } t_tilt;

    typedef enum int {
        MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH
    } t_idle_mode;

    class t_tilt_scoreboard;
        t_tilt pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function void note_input(logic [tilt_pkg::RAW_W-1:0] rx,
                                 logic [tilt_pkg::RAW_W-1:0] ry,
                                 logic [tilt_pkg::RAW_W-1:0] rz);
            pending.push_back(predict_tilt(rx, ry, rz));
        endfunction

        function void check_result(t_tilt got);
            t_tilt exp_t;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            exp_t = pending.pop_front();
            if (got.ax !== exp_t.ax) begin
                $error("angle_x: expected %0d, actual %0d", exp_t.ax, got.ax);
                errors++;
            end
            if (got.ay !== exp_t.ay) begin
                $error("angle_y: expected %0d, actual %0d", exp_t.ay, got.ay);
                errors++;
            end
            if (got.az !== exp_t.az) begin
                $error("angle_z: expected %0d, actual %0d", exp_t.az, got.az);
                errors++;
            end
            if (got.mask !== exp_t.mask) begin
                $error("undefined_mask: expected %0d, actual %0d", exp_t.mask, got.mask);
                errors++;
            end
        endfunction
    endclass

    function automatic longint signed sample_val(logic [tilt_pkg::RAW_W-1:0] raw);
        logic signed [tilt_pkg::MAG_W-1:0] s;
        s = raw[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB];
        return longint'(s);
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res, bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Brings the plain magnitude and the root of the sum to a shared 2^k scale.
    function automatic void align_terms(logic [63:0] a, logic [63:0] s,
                                        output logic [63:0] am, output logic [63:0] rm);
        int blen, k;
        blen = 0;
        for (int i = 0; i < 64; i++) if (s[i]) blen = i + 1;
        k = (62 - blen) / 2;
        am = a << k;
        rm = isqrt64(s << (2 * k));
    endfunction

    function automatic longint signed cordic_degrees(logic [63:0] nm, logic [63:0] dm);
        longint signed x, y, acc, xs, ys;
        x = dm;
        y = nm;
        acc = 0;
        for (int i = 0; i < tilt_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; acc = acc + tilt_pkg::STEP_ANGLE[i];
            end else begin
                x = x - ys; y = y + xs; acc = acc - tilt_pkg::STEP_ANGLE[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(90) <<< tilt_pkg::ACC_FRAC))
            acc = longint'(90) <<< tilt_pkg::ACC_FRAC;
        return acc;
    endfunction

    function automatic logic [tilt_pkg::ANGLE_W-1:0] angle_of(logic [63:0] nm, bit nneg,
                                                             logic [63:0] dm, bit dneg,
                                                             output bit undef);
        longint signed m;
        int sh;
        sh = tilt_pkg::ACC_FRAC - FRAC;
        undef = 0;
        if (nm == 0 && dm == 0) begin
            undef = 1;
            return '0;
        end
        if (nm == 0) return '0;
        if (dm == 0) m = longint'(90) <<< FRAC;
        else m = (cordic_degrees(nm, dm) + (longint'(1) <<< (sh - 1))) >>> sh;
        if (nneg != dneg) m = -m;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        return m[tilt_pkg::ANGLE_W-1:0];
    endfunction

    function automatic t_tilt predict_tilt(logic [tilt_pkg::RAW_W-1:0] rx,
                                           logic [tilt_pkg::RAW_W-1:0] ry,
                                           logic [tilt_pkg::RAW_W-1:0] rz);
        longint signed x, y, z;
        logic [63:0] mx, my, mz, am, rm;
        bit u;
        t_tilt t;
        x = sample_val(rx); y = sample_val(ry); z = sample_val(rz);
        mx = x < 0 ? -x : x;
        my = y < 0 ? -y : y;
        mz = z < 0 ? -z : z;
        t.mask = '0;
        align_terms(mx, my * my + mz * mz, am, rm);
        t.ax = angle_of(am, x < 0, rm, 0, u);
        t.mask[0] = u;
        align_terms(my, mx * mx + mz * mz, am, rm);
        t.ay = angle_of(am, y < 0, rm, 0, u);
        t.mask[1] = u;
        align_terms(mz, mx * mx + my * my, am, rm);
        t.az = angle_of(rm, 0, am, z < 0, u);
        t.mask[2] = u;
        return t;
    endfunction

    logic i_clk;
    logic i_rst_n;
    tilt_in_if  in_ch();
    tilt_out_if out_ch();

    tilt_angles_from_accel #(.ANGLE_FRAC_BITS(FRAC)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_tilt_scoreboard tilt_sb;
    t_idle_mode       idle_mode;
    bit               hold_sink;
    bit               stim_done;
    int               idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        tilt_sb = new();
        idle_mode = MODE_FREE;
        hold_sink = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.raw_x = '0;
        in_ch.raw_y = '0;
        in_ch.raw_z = '0;
        out_ch.ready = 1'b0;
    end

    // Scoreboard sampling at the edge, before the nonblocking updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            tilt_sb.note_input(in_ch.raw_x, in_ch.raw_y, in_ch.raw_z);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tilt_sb.check_result({out_ch.angle_x, out_ch.angle_y, out_ch.angle_z,
                                  out_ch.undefined_mask});
    end

    always @(posedge i_clk) begin
        if (hold_sink)
            out_ch.ready <= 1'b0;
        else if (idle_mode == MODE_SNK_STALL)
            out_ch.ready <= ($urandom_range(99) >= 82);
        else if (idle_mode == MODE_BOTH)
            out_ch.ready <= ($urandom_range(99) >= 36);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [tilt_pkg::RAW_W-1:0] rand_word();
        logic [tilt_pkg::RAW_W-1:0] w;
        logic [31:0] r;
        r = $urandom;
        w = r[tilt_pkg::RAW_W-1:0];
        case ($urandom_range(9))
            0: w[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB] = '0;
            1: w[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB] = {1'b0, {(tilt_pkg::MAG_W-1){1'b1}}};
            2: w[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB] = {1'b1, {(tilt_pkg::MAG_W-1){1'b0}}};
            3: begin
                r = $urandom_range(15);
                w[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB] = r[tilt_pkg::MAG_W-1:0];
            end
            4: begin
                r = -$urandom_range(15);
                w[tilt_pkg::RAW_W-1:tilt_pkg::SMP_LSB] = r[tilt_pkg::MAG_W-1:0];
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_item(logic [tilt_pkg::RAW_W-1:0] rx, logic [tilt_pkg::RAW_W-1:0] ry,
                             logic [tilt_pkg::RAW_W-1:0] rz);
        int gap;
        gap = 0;
        if (idle_mode == MODE_SRC_IDLE || idle_mode == MODE_BOTH) begin
            while ($urandom_range(99) < (idle_mode == MODE_SRC_IDLE ? 82 : 36))
                gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_x <= rx;
        in_ch.raw_y <= ry;
        in_ch.raw_z <= rz;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        logic [tilt_pkg::RAW_W-1:0] neg_full, pos_full, one, mone;
        neg_full = {1'b1, {(tilt_pkg::MAG_W-1){1'b0}}, 4'h0};
        pos_full = {1'b0, {(tilt_pkg::MAG_W-1){1'b1}}, 4'hF};
        one = 24'h000010;
        mone = 24'hFFFFF0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero over zero on every axis, zero denominators, zero numerators,
        // extremes and ignored low nibbles.
        send_item(24'h000000, 24'h000000, 24'h000000);
        send_item(24'h00000F, 24'h00000A, 24'h000005);
        send_item(one, 24'h0, 24'h0);
        send_item(mone, 24'h0, 24'h0);
        send_item(24'h0, one, 24'h0);
        send_item(24'h0, mone, 24'h0);
        send_item(24'h0, 24'h0, one);
        send_item(24'h0, 24'h0, mone);
        send_item(pos_full, pos_full, pos_full);
        send_item(neg_full, neg_full, neg_full);
        send_item(neg_full, pos_full, neg_full);
        send_item(pos_full, 24'h0, 24'h0);
        send_item(neg_full, 24'h0, 24'h0);
        send_item(24'h0, 24'h0, neg_full);
        send_item(one, one, one);
        send_item(mone, mone, mone);
        send_item(pos_full, one, mone);
        send_item(one, neg_full, pos_full);
        send_item(24'hFFFFFF, 24'h00000F, 24'hFFFFFF);
        send_item(24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F);

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = t_idle_mode'(ph);
            for (int n = 0; n < 260; n++) send_item(rand_word(), rand_word(), rand_word());
        end

        // Long receiver hold-off while the sender keeps offering items.
        idle_mode = MODE_FREE;
        fork
            begin
                hold_sink = 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int n = 0; n < 150; n++) send_item(rand_word(), rand_word(), rand_word());
        join
        in_ch.valid <= 1'b0;
        stim_done = 1;

        while (tilt_sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (tilt_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
